// ===== hw/rtl/pcc_pkg.sv =====
// Shared types, function codes and the length lookup for the pulse channel control unit.
`timescale 1ns / 1ps

package pcc_pkg;

  // Function codes carried in the func field of an input transaction
  localparam logic [2:0] FUNC_REG0    = 3'd0;
  localparam logic [2:0] FUNC_REG1    = 3'd1;
  localparam logic [2:0] FUNC_REG2    = 3'd2;
  localparam logic [2:0] FUNC_REG3    = 3'd3;
  localparam logic [2:0] FUNC_ENABLE  = 3'd4;
  localparam logic [2:0] FUNC_QUARTER = 3'd5;
  localparam logic [2:0] FUNC_HALF    = 3'd6;

  localparam logic [3:0]  ENV_COUNT_MAX = 4'd15;
  localparam logic [11:0] PERIOD_MAX    = 12'h7FF;
  localparam logic [11:0] PERIOD_MIN    = 12'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  volume;
    logic [3:0]  envelope_level;
    logic        length_active;
    logic [11:0] period_out;
    logic [1:0]  duty_out;
    logic        muted;
  } out_item_t;

  // One step for the state unit: strobe plus the transaction it applies
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } step_t;

  // Length counter load values
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] r;
    case (idx)
      5'd0:  r = 8'd10;
      5'd1:  r = 8'd254;
      5'd2:  r = 8'd20;
      5'd3:  r = 8'd2;
      5'd4:  r = 8'd40;
      5'd5:  r = 8'd4;
      5'd6:  r = 8'd80;
      5'd7:  r = 8'd6;
      5'd8:  r = 8'd160;
      5'd9:  r = 8'd8;
      5'd10: r = 8'd60;
      5'd11: r = 8'd10;
      5'd12: r = 8'd14;
      5'd13: r = 8'd12;
      5'd14: r = 8'd26;
      5'd15: r = 8'd14;
      5'd16: r = 8'd12;
      5'd17: r = 8'd16;
      5'd18: r = 8'd24;
      5'd19: r = 8'd18;
      5'd20: r = 8'd48;
      5'd21: r = 8'd20;
      5'd22: r = 8'd96;
      5'd23: r = 8'd22;
      5'd24: r = 8'd192;
      5'd25: r = 8'd24;
      5'd26: r = 8'd72;
      5'd27: r = 8'd26;
      5'd28: r = 8'd16;
      5'd29: r = 8'd28;
      5'd30: r = 8'd32;
      5'd31: r = 8'd30;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/pulse_channel_control_unit.sv =====
// Top level of the pulse channel control unit: handshakes, input and result registers.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   event: a write to channel register 0..3, an enable write, a
//   quarter-frame tick or a half-frame tick. Every input transaction
//   produces exactly one result transaction on out_valid/out_ready/out_data
//   reporting the channel state after that event.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes the negate-mode bit;
//   it is always ready and should be written while the unit is idle.
//   Path: an accepted input is held in the input register, then moved to the
//   result register, where out_valid rises; a stall on out_ready can hold it
//   in the input register before that move.
//   Throughput: one transaction per cycle while out_ready is high; the envelope,
//   sweep and length update is a single pass of logic between the two registers.
//   Stall: when out_ready is low the result register holds, the input
//   register can still take one more transaction, and then in_ready drops.
//   Reset (rst, synchronous): clears the channel state, the negate bit and
//   both valid flags; sweep period resets to one.
`timescale 1ns / 1ps

module pulse_channel_control_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic               ones_complement_negate;
  logic               s1_valid;
  pcc_pkg::in_item_t  s1_item;
  logic               advance;
  pcc_pkg::step_t     step;
  pcc_pkg::out_item_t result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      ones_complement_negate <= 1'b0;
    end else if (cfg_valid) begin
      ones_complement_negate <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    step.fire = advance;
    step.item = s1_item;
  end

  pcc_state u_state (
    .clk                    (clk),
    .rst                    (rst),
    .ones_complement_negate (ones_complement_negate),
    .step                   (step),
    .result                 (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // Backpressure only when both stages are full and the result is stalled
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  // An accepted input is always followed by a pending item in stage one
  a_accept_loaded: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction lost");

  // Advancing an item always leaves a valid result
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result not presented after advance");

endmodule

// ===== hw/rtl/pcc_state.sv =====
// Channel state registers with envelope, sweep and length update logic.
`timescale 1ns / 1ps

module pcc_state (
  input  logic               clk,
  input  logic               rst,
  input  logic               ones_complement_negate,
  input  pcc_pkg::step_t     step,
  output pcc_pkg::out_item_t result
);

  logic        chan_enabled,   chan_enabled_next;
  logic [1:0]  duty_sel,       duty_sel_next;
  logic        loop_halt,      loop_halt_next;
  logic        const_vol_flag, const_vol_flag_next;
  logic [3:0]  env_reload_val, env_reload_val_next;
  logic        env_restart,    env_restart_next;
  logic [4:0]  env_divider,    env_divider_next;
  logic [3:0]  env_counter,    env_counter_next;
  logic        sweep_on,       sweep_on_next;
  logic [3:0]  sweep_period,   sweep_period_next;
  logic        sweep_down,     sweep_down_next;
  logic [2:0]  sweep_shift,    sweep_shift_next;
  logic [3:0]  sweep_divider,  sweep_divider_next;
  logic        sweep_restart,  sweep_restart_next;
  logic [11:0] period_reg,     period_reg_next;
  logic [4:0]  length_index,   length_index_next;
  logic [7:0]  length_count,   length_count_next;

  logic [7:0]  v;
  logic        cur_muted;
  logic        next_muted;
  logic [11:0] delta;
  logic [4:0]  env_div_dec;
  logic [4:0]  env_reload_full;

  assign v               = step.item.value;
  assign cur_muted       = (period_reg > pcc_pkg::PERIOD_MAX) ||
                           (period_reg < pcc_pkg::PERIOD_MIN);
  assign delta           = period_reg >> sweep_shift;
  assign env_div_dec     = env_divider - 5'd1;
  assign env_reload_full = {1'b0, env_reload_val} + 5'd1;

  // Next-state logic for one transaction
  always_comb begin
    chan_enabled_next   = chan_enabled;
    duty_sel_next       = duty_sel;
    loop_halt_next      = loop_halt;
    const_vol_flag_next = const_vol_flag;
    env_reload_val_next = env_reload_val;
    env_restart_next    = env_restart;
    env_divider_next    = env_divider;
    env_counter_next    = env_counter;
    sweep_on_next       = sweep_on;
    sweep_period_next   = sweep_period;
    sweep_down_next     = sweep_down;
    sweep_shift_next    = sweep_shift;
    sweep_divider_next  = sweep_divider;
    sweep_restart_next  = sweep_restart;
    period_reg_next     = period_reg;
    length_index_next   = length_index;
    length_count_next   = length_count;
    case (step.item.func)
      pcc_pkg::FUNC_REG0: begin
        duty_sel_next       = v[7:6];
        loop_halt_next      = v[5];
        const_vol_flag_next = v[4];
        env_reload_val_next = v[3:0];
      end
      pcc_pkg::FUNC_REG1: begin
        sweep_on_next      = v[7];
        sweep_period_next  = {1'b0, v[6:4]} + 4'd1;
        sweep_down_next    = v[3];
        sweep_shift_next   = v[2:0];
        sweep_restart_next = 1'b1;
      end
      pcc_pkg::FUNC_REG2: begin
        period_reg_next = {1'b0, period_reg[10:8], v};
      end
      pcc_pkg::FUNC_REG3: begin
        length_index_next = v[7:3];
        period_reg_next   = {1'b0, v[2:0], period_reg[7:0]};
        if (chan_enabled) begin
          length_count_next = pcc_pkg::length_lookup(v[7:3]);
        end
        env_restart_next = 1'b1;
      end
      pcc_pkg::FUNC_ENABLE: begin
        chan_enabled_next = v[0];
        if (!v[0]) begin
          length_count_next = 8'd0;
        end
      end
      pcc_pkg::FUNC_QUARTER: begin
        // Envelope: restart, hold at zero divider, or count down
        if (env_restart) begin
          env_divider_next = env_reload_full;
          env_counter_next = pcc_pkg::ENV_COUNT_MAX;
          env_restart_next = 1'b0;
        end else if (env_divider != 5'd0) begin
          if (env_div_dec == 5'd0) begin
            if (loop_halt && env_counter == 4'd0) begin
              env_counter_next = pcc_pkg::ENV_COUNT_MAX;
            end else if (env_counter != 4'd0) begin
              env_counter_next = env_counter - 4'd1;
            end
            env_divider_next = env_reload_full;
          end else begin
            env_divider_next = env_div_dec;
          end
        end
      end
      pcc_pkg::FUNC_HALF: begin
        // Length counter
        if (!loop_halt && length_count != 8'd0) begin
          length_count_next = length_count - 8'd1;
        end
        // Sweep adjust, underflow wraps in 12 bits
        if (sweep_divider == 4'd0 && sweep_on && !cur_muted) begin
          if (sweep_down) begin
            period_reg_next = period_reg - delta - {11'd0, ones_complement_negate};
          end else begin
            period_reg_next = period_reg + delta;
          end
        end
        if (sweep_divider == 4'd0 || sweep_restart) begin
          sweep_divider_next = sweep_period;
          sweep_restart_next = 1'b0;
        end else begin
          sweep_divider_next = sweep_divider - 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result reflects the state after the transaction
  assign next_muted = (period_reg_next > pcc_pkg::PERIOD_MAX) ||
                      (period_reg_next < pcc_pkg::PERIOD_MIN);

  always_comb begin
    result.volume         = next_muted ? 4'd0 : env_reload_val_next;
    result.envelope_level = env_counter_next;
    result.length_active  = (length_count_next != 8'd0);
    result.period_out     = period_reg_next;
    result.duty_out       = duty_sel_next;
    result.muted          = next_muted;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_enabled   <= 1'b0;
      duty_sel       <= 2'd0;
      loop_halt      <= 1'b0;
      const_vol_flag <= 1'b0;
      env_reload_val <= 4'd0;
      env_restart    <= 1'b0;
      env_divider    <= 5'd0;
      env_counter    <= 4'd0;
      sweep_on       <= 1'b0;
      sweep_period   <= 4'd1;
      sweep_down     <= 1'b0;
      sweep_shift    <= 3'd0;
      sweep_divider  <= 4'd0;
      sweep_restart  <= 1'b0;
      period_reg     <= 12'd0;
      length_index   <= 5'd0;
      length_count   <= 8'd0;
    end else if (step.fire) begin
      chan_enabled   <= chan_enabled_next;
      duty_sel       <= duty_sel_next;
      loop_halt      <= loop_halt_next;
      const_vol_flag <= const_vol_flag_next;
      env_reload_val <= env_reload_val_next;
      env_restart    <= env_restart_next;
      env_divider    <= env_divider_next;
      env_counter    <= env_counter_next;
      sweep_on       <= sweep_on_next;
      sweep_period   <= sweep_period_next;
      sweep_down     <= sweep_down_next;
      sweep_shift    <= sweep_shift_next;
      sweep_divider  <= sweep_divider_next;
      sweep_restart  <= sweep_restart_next;
      period_reg     <= period_reg_next;
      length_index   <= length_index_next;
      length_count   <= length_count_next;
    end
  end

  // Divider reloads never exceed their field ranges
  a_env_div_range: assert property (@(posedge clk) disable iff (rst)
    env_divider <= 5'd16)
    else $error("envelope divider out of range");

  a_sweep_div_range: assert property (@(posedge clk) disable iff (rst)
    (sweep_divider <= 4'd8) && (sweep_period >= 4'd1) && (sweep_period <= 4'd8))
    else $error("sweep divider or period out of range");

  // A length load with the channel disabled leaves the counter at zero
  a_len_zero_disabled: assert property (@(posedge clk) disable iff (rst)
    !chan_enabled |-> length_count == 8'd0)
    else $error("length counter nonzero while disabled");

  // Register 3 write arms the envelope restart
  a_env_restart: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.item.func == pcc_pkg::FUNC_REG3 |=> env_restart)
    else $error("envelope restart not armed");

  // Stored length index always matches the last register 3 write
  a_len_index: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.item.func == pcc_pkg::FUNC_REG3 |=>
      length_index == $past(step.item.value[7:3]))
    else $error("length index not captured");

endmodule

// ===== tb/sv/pcc_status_checker.sv =====
// Checker for the pulse channel control unit: predicts each status result and compares it.
`timescale 1ns / 1ps

module pcc_status_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pcc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pcc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 errors,
  output int                 outstanding
);

  // Length counter load values, indexed by the 5-bit field of register 3
  localparam logic [0:31][7:0] LENGTH_LOAD = {
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Predicted channel state (constant-volume flag is never reported, so not kept)
  logic        negate_extra;
  logic        chan_en;
  logic [1:0]  duty;
  logic        halt_loop;
  logic [3:0]  env_vol;
  logic        env_start;
  logic [4:0]  env_div;
  logic [3:0]  env_cnt;
  logic        sw_en;
  logic [3:0]  sw_per;
  logic        sw_neg;
  logic [2:0]  sw_shift;
  logic [3:0]  sw_div;
  logic        sw_reload;
  logic [11:0] period;
  logic [7:0]  len_cnt;

  pcc_pkg::out_item_t status_q[$];
  int                 mismatches = 0;

  function automatic logic period_silent(input logic [11:0] p);
    return (p > pcc_pkg::PERIOD_MAX) || (p < pcc_pkg::PERIOD_MIN);
  endfunction

  task automatic reset_channel();
    negate_extra = 1'b0;
    chan_en      = 1'b0;
    duty         = '0;
    halt_loop    = 1'b0;
    env_vol      = '0;
    env_start    = 1'b0;
    env_div      = '0;
    env_cnt      = '0;
    sw_en        = 1'b0;
    sw_per       = 4'd1;
    sw_neg       = 1'b0;
    sw_shift     = '0;
    sw_div       = '0;
    sw_reload    = 1'b0;
    period       = '0;
    len_cnt      = '0;
  endtask

  // Apply one event to the predicted state and report the status after it
  task automatic advance_channel(input pcc_pkg::in_item_t ev,
                                 output pcc_pkg::out_item_t st);
    logic [11:0] delta;
    logic        silent;
    case (ev.func)
      pcc_pkg::FUNC_REG0: begin
        duty      = ev.value[7:6];
        halt_loop = ev.value[5];
        env_vol   = ev.value[3:0];
      end
      pcc_pkg::FUNC_REG1: begin
        sw_en     = ev.value[7];
        sw_per    = {1'b0, ev.value[6:4]} + 4'd1;
        sw_neg    = ev.value[3];
        sw_shift  = ev.value[2:0];
        sw_reload = 1'b1;
      end
      pcc_pkg::FUNC_REG2: begin
        // bit 11 is dropped by either period write
        period = {1'b0, period[10:8], ev.value};
      end
      pcc_pkg::FUNC_REG3: begin
        period = {1'b0, ev.value[2:0], period[7:0]};
        if (chan_en) len_cnt = LENGTH_LOAD[ev.value[7:3]];
        env_start = 1'b1;
      end
      pcc_pkg::FUNC_ENABLE: begin
        chan_en = ev.value[0];
        if (!chan_en) len_cnt = '0;
      end
      pcc_pkg::FUNC_QUARTER: begin
        // envelope: restart, or a divider that holds at zero before first restart
        if (env_start) begin
          env_div   = {1'b0, env_vol} + 5'd1;
          env_cnt   = pcc_pkg::ENV_COUNT_MAX;
          env_start = 1'b0;
        end else if (env_div != '0) begin
          env_div = env_div - 5'd1;
          if (env_div == '0) begin
            if (halt_loop && env_cnt == '0) env_cnt = pcc_pkg::ENV_COUNT_MAX;
            else if (env_cnt != '0) env_cnt = env_cnt - 4'd1;
            env_div = {1'b0, env_vol} + 5'd1;
          end
        end
      end
      pcc_pkg::FUNC_HALF: begin
        if (!halt_loop && len_cnt != '0) len_cnt = len_cnt - 8'd1;
        // sweep acts only on an audible period; a downward result may wrap
        if (sw_div == '0 && sw_en && !period_silent(period)) begin
          delta = period >> sw_shift;
          if (sw_neg) period = period - delta - {11'd0, negate_extra};
          else period = period + delta;
        end
        if (sw_div == '0 || sw_reload) begin
          sw_div    = sw_per;
          sw_reload = 1'b0;
        end else begin
          sw_div = sw_div - 4'd1;
        end
      end
      default: ;
    endcase
    silent            = period_silent(period);
    st.volume         = silent ? 4'd0 : env_vol;
    st.envelope_level = env_cnt;
    st.length_active  = (len_cnt != '0);
    st.period_out     = period;
    st.duty_out       = duty;
    st.muted          = silent;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Watch all three channels; results are checked before new events are queued
  always @(posedge clk) begin : monitor
    pcc_pkg::out_item_t want_st;
    pcc_pkg::out_item_t next_st;
    if (rst) begin
      reset_channel();
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) negate_extra = cfg_data;
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want_st = status_q.pop_front();
          check_field("volume", int'(want_st.volume), int'(out_data.volume));
          check_field("envelope_level", int'(want_st.envelope_level),
                      int'(out_data.envelope_level));
          check_field("length_active", int'(want_st.length_active),
                      int'(out_data.length_active));
          check_field("period_out", int'(want_st.period_out),
                      int'(out_data.period_out));
          check_field("duty_out", int'(want_st.duty_out), int'(out_data.duty_out));
          check_field("muted", int'(want_st.muted), int'(out_data.muted));
        end
      end
      if (in_valid && in_ready) begin
        advance_channel(in_data, next_st);
        status_q.push_back(next_st);
      end
    end
    errors      <= mismatches;
    outstanding <= status_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the pulse channel control unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] FUNC_UNUSED  = 3'd7;
  localparam int         QUIET_LIMIT  = 1000;
  localparam int         RANDOM_ITEMS = 200;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pcc_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pcc_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data  = 1'b0;
  logic               calm      = 1'b0;
  logic [15:0]        cyc       = '0;
  int                 errors;
  int                 outstanding;

  pulse_channel_control_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pcc_status_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // Free-running count; its bits 8 and 7 open and close the stall windows
  always @(posedge clk) begin
    cyc <= cyc + 16'd1;
  end

  // Result side back-pressure in bursts
  initial begin : sink_stalls
    forever begin
      @(posedge clk);
      if (!calm && cyc[8:7] != 2'd0 && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Ends the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("pulse_channel_control_unit verification failed");
    $finish;
  end

  // Present one event and hold it until the unit takes it; valid stays high
  task automatic push_event(input logic [2:0] f, input logic [7:0] v);
    in_data  <= '{func: f, value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && cyc[7] && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every owed result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_negate(input logic b);
    cfg_data  <= b;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Ticks make up half of the single events; register writes and whole note setups are mixed in
  task automatic run_random(input int count);
    int          sent;
    int          r;
    logic [2:0]  f;
    logic [7:0]  v;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < 4; k++) begin
          push_event(pcc_pkg::FUNC_REG0 + 3'(k), 8'($urandom_range(0, 255)));
          maybe_idle();
        end
        sent += 4;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) f = pcc_pkg::FUNC_QUARTER;
        else if (r < 50) f = pcc_pkg::FUNC_HALF;
        else if (r < 60) f = pcc_pkg::FUNC_REG0;
        else if (r < 68) f = pcc_pkg::FUNC_REG1;
        else if (r < 78) f = pcc_pkg::FUNC_REG2;
        else if (r < 88) f = pcc_pkg::FUNC_REG3;
        else if (r < 97) f = pcc_pkg::FUNC_ENABLE;
        else f = FUNC_UNUSED;
        v = 8'($urandom_range(0, 255));
        // keep the channel enabled most of the time so lengths load
        if (f == pcc_pkg::FUNC_ENABLE && $urandom_range(0, 3) != 0) v[0] = 1'b1;
        push_event(f, v);
        maybe_idle();
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain negate: held zero divider, unused code, disabled length load
    write_negate(1'b0);
    push_event(pcc_pkg::FUNC_QUARTER, 8'h00);
    push_event(FUNC_UNUSED, 8'hA5);
    push_event(pcc_pkg::FUNC_REG3, 8'hFF);
    push_event(pcc_pkg::FUNC_ENABLE, 8'h01);
    push_event(pcc_pkg::FUNC_REG0, 8'hFF);
    push_event(pcc_pkg::FUNC_REG2, 8'hFF);
    push_event(pcc_pkg::FUNC_QUARTER, 8'h00);
    push_event(pcc_pkg::FUNC_REG3, 8'h08);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    // upward sweep with shift zero doubles the period
    push_event(pcc_pkg::FUNC_REG1, 8'h80);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_REG0, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_ENABLE, 8'h00);
    wait_drained();

    // extra-one negate: downward sweep from period 8 wraps below zero
    write_negate(1'b1);
    push_event(pcc_pkg::FUNC_REG1, 8'h88);
    push_event(pcc_pkg::FUNC_REG2, 8'h08);
    push_event(pcc_pkg::FUNC_REG3, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_HALF, 8'h00);
    push_event(pcc_pkg::FUNC_REG1, 8'hF7);
    run_random(RANDOM_ITEMS);
    wait_drained();

    write_negate(1'b0);
    run_random(RANDOM_ITEMS);
    wait_drained();

    // last stretch at full rate on both sides
    write_negate(1'b1);
    calm <= 1'b1;
    run_random(RANDOM_ITEMS);
    wait_drained();
    repeat (6) @(posedge clk);

    if (errors == 0) begin
      $display("pulse_channel_control_unit verification clean");
    end else begin
      $display("pulse_channel_control_unit verification failed");
    end
    $finish;
  end

endmodule
